>>> hw/rtl/sradx_pkg.sv
// Shared constants, types and the symbol lookup of the signed radix digit emitter.
// No dependencies; every other file of the block imports this package.
package sradx_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int MAX_BASE     = 16;
   localparam int SYMBOL_SLOTS = 16;
   localparam int SYM_W        = 8;
   localparam int DIGIT_W      = 4;
   localparam int RADIX_W      = 5;
   localparam int DIGIT_DEPTH  = 32;
   localparam int IDX_W        = $clog2(DIGIT_DEPTH);
   localparam int COUNT_W      = IDX_W + 1;
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
   localparam int PAD_W        = DIV_STEPS * DIV_BITS;
   localparam int STEP_W       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int MIN_RADIX    = 2;

   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
   localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYMBOLS_LOW  = 2'd0,
      CSR_SYMBOLS_HIGH = 2'd1,
      CSR_RADIX        = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                   neg;
      logic [VALUE_WIDTH-1:0] magnitude;
   } job_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_type;

   function automatic logic [SYM_W-1:0] symbol_at(input logic [CSR_DATA_W-1:0] lo,
                                                  input logic [CSR_DATA_W-1:0] hi,
                                                  input logic [DIGIT_W-1:0]    d);
      logic [5:0] base;
      base = {d[2:0], 3'b000};
      return d[3] ? hi[base +: SYM_W] : lo[base +: SYM_W];
   endfunction

endpackage

>>> hw/rtl/sradx_front.sv
// Front end: accepts values, checks the symbol table and forms the magnitude job.
// Depends on sradx_pkg.
module sradx_front (
   input  logic                            req_push,
   input  logic [sradx_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]  symbols_low,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]  symbols_high,
   input  logic [sradx_pkg::RADIX_W-1:0]     radix,
   input  logic                            job_full,
   output logic                            req_full,
   output logic                            job_push,
   output sradx_pkg::job_type              job_data,
   output logic                            table_ok
);
   import sradx_pkg::*;

   logic [SYMBOL_SLOTS-1:0] used;
   logic [SYM_W-1:0]        sym [SYMBOL_SLOTS];
   logic                    bad;
   logic [VALUE_WIDTH-1:0]  raw;

   always_comb begin
      bad = (radix < RADIX_W'(MIN_RADIX)) || (radix > RADIX_W'(MAX_BASE));
      for (int i = 0; i < SYMBOL_SLOTS; i++) begin
         used[i] = RADIX_W'(i) < radix;
         sym[i]  = symbol_at(symbols_low, symbols_high, DIGIT_W'(i));
         if (used[i] && (sym[i] == SYM_PLUS || sym[i] == SYM_MINUS ||
                         sym[i] == SYM_SPACE || sym[i] == SYM_NUL)) begin
            bad = 1'b1;
         end
      end
      // used[j] implies used[i] for i < j
      for (int i = 0; i < SYMBOL_SLOTS; i++) begin
         for (int j = i + 1; j < SYMBOL_SLOTS; j++) begin
            if (used[j] && sym[i] == sym[j]) begin
               bad = 1'b1;
            end
         end
      end
   end

   assign table_ok = !bad;
   assign raw      = req_value;
   assign req_full = job_full;

   // drop items under an invalid table
   assign job_push           = req_push && !job_full && table_ok;
   assign job_data.neg       = raw[VALUE_WIDTH-1];
   assign job_data.magnitude = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

endmodule

>>> hw/rtl/sradx_job_queue.sv
// Two-entry queue of conversion jobs between front and back end.
// Depends on sradx_pkg.
module sradx_job_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sradx_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output sradx_pkg::job_type pop_data
);
   import sradx_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/sradx_back.sv
// Back end: iterative digit division, digit store and character emission
// into a two-entry result queue. Depends on sradx_pkg.
module sradx_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]  symbols_low,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]  symbols_high,
   input  logic [sradx_pkg::RADIX_W-1:0]     radix,
   input  logic                            job_valid,
   input  sradx_pkg::job_type              job_data,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output sradx_pkg::rsp_type              rsp_data
);
   import sradx_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SIGN = 5'b00100,
      ST_LOAD = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [PAD_W-1:0]     quot_ff, quot_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [COUNT_W-1:0]   k_ff, k_in;
   logic                 neg_ff, neg_in;
   logic [DIGIT_W-1:0]   digit_store [DIGIT_DEPTH];
   logic [DIGIT_W-1:0]   digit_rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 store_we;
   logic [PAD_W-1:0]     q_step;
   logic [DIGIT_W-1:0]   r_step;
   logic [DIGIT_W:0]     r_wide;
   logic [COUNT_W-1:0]   n_next;

   rsp_type              out_slot_ff [2];
   logic                 out_wr_ff, out_rd_ff;
   logic [1:0]           out_count_ff;
   logic                 out_full, out_push, out_pop;
   rsp_type              out_item;

   // DIV_BITS restoring steps on a narrow remainder
   always_comb begin
      q_step = quot_ff;
      r_step = rem_ff;
      for (int b = 0; b < DIV_BITS; b++) begin
         r_wide = {r_step, q_step[PAD_W-1]};
         q_step = {q_step[PAD_W-2:0], 1'b0};
         if (r_wide >= radix) begin
            r_wide    = r_wide - radix;
            q_step[0] = 1'b1;
         end
         r_step = r_wide[DIGIT_W-1:0];
      end
   end

   assign n_next   = n_ff + COUNT_W'(1);
   assign rd_addr  = IDX_W'(k_ff - COUNT_W'(1));
   assign out_full = out_count_ff == 2'd2;

   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      neg_in   = neg_ff;
      job_pop  = 1'b0;
      store_we = 1'b0;
      out_push = 1'b0;
      out_item.symbol = symbol_at(symbols_low, symbols_high, digit_rd_ff);
      out_item.last   = k_ff == COUNT_W'(1);
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               quot_in  = PAD_W'(job_data.magnitude);
               rem_in   = '0;
               step_in  = '0;
               n_in     = '0;
               neg_in   = job_data.neg;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = q_step;
            rem_in  = r_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               store_we = 1'b1;
               n_in     = n_next;
               step_in  = '0;
               rem_in   = '0;
               if (q_step == '0 || n_next >= COUNT_W'(DIGIT_DEPTH)) begin
                  k_in     = n_next;
                  state_in = neg_ff ? ST_SIGN : ST_LOAD;
               end
            end
         end
         ST_SIGN: begin
            out_item.symbol = SYM_MINUS;
            out_item.last   = 1'b0;
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               k_in     = k_ff - COUNT_W'(1);
               state_in = (k_ff == COUNT_W'(1)) ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[n_ff[IDX_W-1:0]] <= r_step;
      end
      digit_rd_ff <= digit_store[rd_addr];
   end

   // result queue
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_empty = out_count_ff == 2'd0;
   assign rsp_data  = out_slot_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         out_wr_ff    <= out_wr_ff ^ out_push;
         out_rd_ff    <= out_rd_ff ^ out_pop;
         out_count_ff <= out_count_ff + {1'b0, out_push} - {1'b0, out_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_slot_ff[out_wr_ff] <= out_item;
      end
   end

endmodule

>>> hw/rtl/signed_radix_digit_emitter_core.sv
// Top level of the signed radix digit emitter: configuration registers,
// front end, job queue and back end. Depends on sradx_pkg and the sradx_ modules.
//
// Push a signed 32-bit value and pop its text, one symbol byte per item, most
// significant digit first, rsp_last marking the final byte; a negative value
// starts with '-'. Digit d is byte d of the 16-byte symbol table (csr index 0
// holds digits 0-7, index 1 digits 8-15, index 2 the radix). Values pushed
// while the table is invalid (radix outside 2..16, a '+', '-', space or zero
// byte among the used symbols, or a repeated symbol) are taken and dropped.
// The back end divides by the radix four quotient bits per cycle and stores one
// digit after each full division pass, then passes each digit byte through a load
// and an emit state; the two-entry job queue lets the next values enter while one
// converts.
module signed_radix_digit_emitter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [sradx_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [sradx_pkg::SYM_W-1:0]       rsp_symbol,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [sradx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sradx_pkg::*;

   logic [CSR_DATA_W-1:0] symbols_low_ff;
   logic [CSR_DATA_W-1:0] symbols_high_ff;
   logic [RADIX_W-1:0]    radix_ff;
   logic                  job_full, job_push, job_valid, job_pop, table_ok;
   job_type               job_in, job_out;
   rsp_type               rsp_data;

   // Hold configuration; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         radix_ff        <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            CSR_RADIX:        radix_ff        <= csr_data[RADIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Classify and form the magnitude.
   sradx_front u_front (
      .req_push     (req_push),
      .req_value    (req_value),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .radix        (radix_ff),
      .job_full     (job_full),
      .req_full     (req_full),
      .job_push     (job_push),
      .job_data     (job_in),
      .table_ok     (table_ok)
   );

   // Decouple acceptance from conversion.
   sradx_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (job_out)
   );

   // Divide, store digits, emit bytes.
   sradx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .radix        (radix_ff),
      .job_valid    (job_valid),
      .job_data     (job_out),
      .job_pop      (job_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   assign rsp_symbol = rsp_data.symbol;
   assign rsp_last   = rsp_data.last;

   // Results only appear under a valid table.
   a_rsp_needs_table: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> table_ok)
      else $error("result present while symbol table is invalid");

   // A minus sign is never the final byte of a run.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_symbol == SYM_MINUS) |-> !rsp_last)
      else $error("minus sign marked as last byte");

   // Reset leaves no result queued.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

endmodule

>>> bench/sradx_checker.sv
// Checker for signed_radix_digit_emitter_core: mirrors the symbol table, predicts the
// text of each accepted value and compares every popped symbol with it.
// Depends on sradx_pkg for widths, symbol constants, register indexes and rsp_type.
module sradx_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   input  logic                                     req_full,
   input  logic signed [sradx_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   input  logic [sradx_pkg::SYM_W-1:0]              rsp_symbol,
   input  logic                                     rsp_last,
   input  logic                                     csr_write_enable,
   input  logic [sradx_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sradx_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic                                     run_done,
   output int                                       fail_count,
   output int                                       pending_count,
   output int                                       value_count,
   output int                                       dropped_count,
   output int                                       symbol_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sradx_pkg::*;

   localparam int SHOWN_MISMATCHES = 25;

   logic [CSR_DATA_W-1:0] table_lo;
   logic [CSR_DATA_W-1:0] table_hi;
   logic [RADIX_W-1:0]    radix_setting;
   rsp_type               expected_text[$];
   bit                    leftover_checked;

   task automatic report_mismatch(input string what);
      if (fail_count < SHOWN_MISMATCHES) begin
         $display("[%0t ns] mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   function automatic bit table_is_valid();
      logic [2*CSR_DATA_W-1:0] table_bits;
      logic [SYM_W-1:0]        sym;
      int                      i;
      int                      j;
      table_bits = {table_hi, table_lo};
      if (radix_setting < MIN_RADIX || radix_setting > MAX_BASE) return 1'b0;
      for (i = 0; i < radix_setting; i++) begin
         sym = table_bits[8*i +: SYM_W];
         if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_SPACE || sym == SYM_NUL)
            return 1'b0;
         for (j = i + 1; j < radix_setting; j++) begin
            if (table_bits[8*j +: SYM_W] == sym) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Queue the text of one value: optional '-', then digits most significant first.
   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
      logic [2*CSR_DATA_W-1:0] table_bits;
      logic [VALUE_WIDTH-1:0]  rest;
      logic [VALUE_WIDTH-1:0]  base;
      logic [DIGIT_W-1:0]      digits[DIGIT_DEPTH];
      rsp_type                 item;
      int                      n;
      int                      k;
      if (!table_is_valid()) begin
         dropped_count++;
         return;
      end
      value_count++;
      table_bits = {table_hi, table_lo};
      base = VALUE_WIDTH'(radix_setting);
      // Negate in unsigned arithmetic so the most negative value maps to 2^31.
      rest = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      digits[0] = DIGIT_W'(rest % base);
      rest = rest / base;
      n = 1;
      while (rest != 0 && n < DIGIT_DEPTH) begin
         digits[n] = DIGIT_W'(rest % base);
         rest = rest / base;
         n++;
      end
      if (raw[VALUE_WIDTH-1]) begin
         item.symbol = SYM_MINUS;
         item.last   = 1'b0;
         expected_text.push_back(item);
      end
      for (k = n - 1; k >= 0; k--) begin
         item.symbol = table_bits[8*digits[k] +: SYM_W];
         item.last   = (k == 0);
         expected_text.push_back(item);
      end
   endfunction

   task automatic check_symbol();
      rsp_type want;
      symbol_count++;
      if (expected_text.size() == 0) begin
         report_mismatch($sformatf("symbol 0x%02h last %0b popped with nothing expected",
                                   rsp_symbol, rsp_last));
         return;
      end
      want = expected_text.pop_front();
      if (rsp_symbol !== want.symbol)
         report_mismatch($sformatf("symbol 0x%02h, expected 0x%02h", rsp_symbol, want.symbol));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0b on symbol 0x%02h, expected %0b",
                                   rsp_last, want.symbol, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         table_lo         = '0;
         table_hi         = '0;
         radix_setting    = '0;
         expected_text.delete();
         leftover_checked = 1'b0;
         fail_count       = 0;
         value_count      = 0;
         dropped_count    = 0;
         symbol_count     = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SYMBOLS_LOW:  table_lo = csr_data;
               CSR_SYMBOLS_HIGH: table_hi = csr_data;
               CSR_RADIX:        radix_setting = csr_data[RADIX_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) predict_text(req_value);
         if (rsp_pop && !rsp_empty) check_symbol();
         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_text.size() != 0)
               report_mismatch($sformatf("%0d expected symbols never arrived",
                                         expected_text.size()));
         end
      end
      pending_count <= expected_text.size();
   end

endmodule

>>> bench/tb_top.sv
// Top of the signed_radix_digit_emitter_core bench: clock, reset, stimulus, output
// back-pressure, watchdog and verdict. Depends on sradx_pkg, the core and sradx_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sradx_pkg::*;

   // Settle after draining before touching the table.
   localparam int SETTLE_CYCLES    = 400;
   localparam int LONG_HOLD_CYCLES = 1500;
   // Worst honest gap between two handshakes: long output hold plus a few full
   // conversions, a sender gap and a settle pause.
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 58;
   localparam int INVALID_ITEMS    = 4;
   localparam int DIRECTED_BAD     = 9;

   // Index with no register behind it; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   // Decimal digits; the unused upper slots carry '-', ' ', zero, '+' and a repeat,
   // which must not matter while radix is 10.
   localparam logic [CSR_DATA_W-1:0] DEC_LO = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] DEC_HI = 64'h0038_2B00_202D_3938;
   localparam logic [CSR_DATA_W-1:0] HEX_LO = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;
   // Binary with the extreme symbol bytes 0xFF and 0x01, junk in unused slots.
   localparam logic [CSR_DATA_W-1:0] BIN_LO = 64'h2D2D_2D2D_2D2D_01FF;
   localparam logic [CSR_DATA_W-1:0] BIN_HI = 64'h0000_0000_0000_0000;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic [SYM_W-1:0]              rsp_symbol;
   logic                          rsp_last;
   logic                          csr_write_enable;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;
   logic                          run_done;

   int fail_count;
   int pending_count;
   int value_count;
   int dropped_count;
   int symbol_count;
   int idle_cycles = 0;
   int table_settings = 0;
   bit hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   signed_radix_digit_emitter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   sradx_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .run_done         (run_done),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .value_count      (value_count),
      .dropped_count    (dropped_count),
      .symbol_count     (symbol_count)
   );

   // Offer one value and hold it until the core takes it. Push stays high on
   // return so that the next value can follow back to back.
   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      req_push  <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop push and hold until every predicted symbol has been popped.
   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
   endtask

   // Reprogram the whole table, but only once the core is idle.
   task automatic load_table(input logic [CSR_DATA_W-1:0] lo,
                             input logic [CSR_DATA_W-1:0] hi,
                             input logic [CSR_DATA_W-1:0] radix_word,
                             input bit                    poke_spare);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (poke_spare) write_register(CSR_SPARE, '1);
      write_register(CSR_SYMBOLS_LOW, lo);
      write_register(CSR_SYMBOLS_HIGH, hi);
      write_register(CSR_RADIX, radix_word);
      csr_write_enable <= 1'b0;
      table_settings++;
   endtask

   // Distinct legal symbols in the used slots, anything at all in the rest.
   function automatic void random_table(input int base,
                                        output logic [CSR_DATA_W-1:0] lo,
                                        output logic [CSR_DATA_W-1:0] hi);
      logic [2*CSR_DATA_W-1:0] table_bits;
      logic [SYM_W-1:0]        sym;
      bit                      clash;
      int                      i;
      int                      j;
      for (i = 0; i < SYMBOL_SLOTS; i++)
         table_bits[8*i +: SYM_W] = SYM_W'($urandom_range(0, 255));
      for (i = 0; i < base; i++) begin
         clash = 1'b1;
         while (clash) begin
            sym   = SYM_W'($urandom_range(1, 255));
            clash = (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_SPACE);
            for (j = 0; j < i; j++) if (table_bits[8*j +: SYM_W] == sym) clash = 1'b1;
         end
         table_bits[8*i +: SYM_W] = sym;
      end
      {hi, lo} = table_bits;
   endfunction

   // Mix of small numbers, extremes, powers of the radix and their neighbors,
   // values of random bit length and plain random words.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input int base);
      longint unsigned                power;
      int                             steps;
      int                             k;
      logic signed [VALUE_WIDTH-1:0]  value;
      case ($urandom_range(0, 7))
         0: value = $urandom_range(0, 2 * base);
         1: value = 32'd0 - $urandom_range(1, 300);
         2: begin
            case ($urandom_range(0, 4))
               0:       value = 0;
               1:       value = MOST_POSITIVE;
               2:       value = MOST_NEGATIVE;
               3:       value = -1;
               default: value = MOST_NEGATIVE + 1;
            endcase
         end
         3: begin
            power = 1;
            steps = $urandom_range(1, 31);
            for (k = 0; k < steps && power * base <= 64'h8000_0000; k++) power = power * base;
            value = VALUE_WIDTH'(power + $urandom_range(0, 2) - 1);
            if ($urandom_range(0, 1)) value = -value;
         end
         4: begin
            value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) value = -value;
         end
         default: value = $urandom;
      endcase
      return value;
   endfunction

   // Output side: stretches of always-pop, coin-flip pop, periodic pop and
   // hold-then-release, plus one long hold on request from the stimulus.
   initial begin : receiver
      int style;
      int stretch;
      int period;
      int k;
      rsp_pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(10, 300);
         period  = $urandom_range(2, 9);
         for (k = 0; k < stretch; k++) begin
            case (style)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= (k % period == 0);
               default: rsp_pop <= (k >= stretch / 2);
            endcase
            @(posedge clock);
         end
      end
   end

   // Restart the count on every handshake; a long silence means a hang.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d symbols still expected",
                  WATCHDOG_LIMIT, pending_count);
         $display("signed_radix_digit_emitter_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [2*CSR_DATA_W-1:0] table_bits;
      logic [CSR_DATA_W-1:0]   lo;
      logic [CSR_DATA_W-1:0]   hi;
      logic [CSR_DATA_W-1:0]   radix_word;
      int                      phase;
      int                      base;
      int                      n;
      int                      burst_left;
      int                      gap;
      int                      slot;
      int                      other;
      bit                      steady;

      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_value        <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SYMBOLS_LOW;
      csr_data         <= '0;
      run_done         <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Decimal: zero, single digits, carries, both extremes. Radix is written
      // with junk above bit 4, and the unused index gets a write too.
      load_table(DEC_LO, DEC_HI, 64'hFFFF_FFFF_FFFF_FFE0 | 64'd10, 1'b1);
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(10);
      send_value(-10);
      send_value(MOST_POSITIVE);
      send_value(MOST_NEGATIVE);
      send_value(1000000000);
      send_value(-123456789);

      // Full sixteen-symbol table.
      load_table(HEX_LO, HEX_HI, 64'd16, 1'b0);
      send_value(32'sh1234_5678);
      send_value(-1);
      send_value(MOST_NEGATIVE);
      send_value(MOST_POSITIVE);
      send_value(15);
      send_value(16);

      // Binary: the most negative value gives the longest run, a sign and 32 digits.
      load_table(BIN_LO, BIN_HI, 64'd2, 1'b0);
      send_value(MOST_NEGATIVE);
      send_value(MOST_POSITIVE);
      send_value(0);
      send_value(5);

      // Broken tables: values are taken and must produce nothing.
      for (n = 0; n < DIRECTED_BAD; n++) begin
         table_bits = {HEX_HI, HEX_LO};
         radix_word = 64'd16;
         case (n)
            0: radix_word = 64'd0;
            1: radix_word = 64'd1;
            2: radix_word = 64'd17;
            3: radix_word = '1;
            4: table_bits[8*15 +: SYM_W] = SYM_PLUS;
            5: table_bits[8*0 +: SYM_W]  = SYM_MINUS;
            6: table_bits[8*7 +: SYM_W]  = SYM_SPACE;
            7: table_bits[8*9 +: SYM_W]  = SYM_NUL;
            default: table_bits[8*12 +: SYM_W] = table_bits[8*3 +: SYM_W];
         endcase
         load_table(table_bits[CSR_DATA_W-1:0], table_bits[2*CSR_DATA_W-1:CSR_DATA_W],
                    radix_word, 1'b0);
         send_value($urandom);
      end

      // Random tables and values. Every third phase uses a broken table.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 3 == 2) begin
            base = $urandom_range(2, 16);
            random_table(base, lo, hi);
            table_bits = {hi, lo};
            radix_word = {$urandom, $urandom};
            radix_word[RADIX_W-1:0] = RADIX_W'(base);
            case ($urandom_range(0, 2))
               0: radix_word[RADIX_W-1:0] = ($urandom_range(0, 1) != 0) ?
                                             RADIX_W'($urandom_range(0, 1)) :
                                             RADIX_W'($urandom_range(17, 31));
               1: begin
                  slot = $urandom_range(0, base - 1);
                  case ($urandom_range(0, 3))
                     0:       table_bits[8*slot +: SYM_W] = SYM_PLUS;
                     1:       table_bits[8*slot +: SYM_W] = SYM_MINUS;
                     2:       table_bits[8*slot +: SYM_W] = SYM_SPACE;
                     default: table_bits[8*slot +: SYM_W] = SYM_NUL;
                  endcase
               end
               default: begin
                  slot  = $urandom_range(1, base - 1);
                  other = $urandom_range(0, slot - 1);
                  table_bits[8*slot +: SYM_W] = table_bits[8*other +: SYM_W];
               end
            endcase
            load_table(table_bits[CSR_DATA_W-1:0], table_bits[2*CSR_DATA_W-1:CSR_DATA_W],
                       radix_word, 1'b0);
            for (n = 0; n < INVALID_ITEMS; n++) send_value(pick_value(base));
            continue;
         end

         // First two valid phases pin the radix extremes.
         base = (phase == 0) ? MAX_BASE : (phase == 1) ? MIN_RADIX : $urandom_range(2, 16);
         random_table(base, lo, hi);
         radix_word = {$urandom, $urandom};
         radix_word[RADIX_W-1:0] = RADIX_W'(base);
         load_table(lo, hi, radix_word, 1'b0);

         // Stall the output long enough for the core to fill up and assert full.
         if (phase == 0) hold_request = 1'b1;
         steady     = (phase == 3);
         burst_left = 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, let the core run completely dry before going on.
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_for_drain();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               if (!steady) begin
                  gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) :
                                                      $urandom_range(0, 4);
                  if (gap > 0) pause_sender(gap);
               end
            end
            send_value(pick_value(base));
            burst_left--;
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("run covered %0d converted values and %0d symbols over %0d table settings,",
               value_count, symbol_count, table_settings);
      $display("plus %0d values dropped under broken tables; radix 2 and 16 both exercised",
               dropped_count);
      if (fail_count == 0) begin
         $display("signed_radix_digit_emitter_core regression: pass");
      end else begin
         $display("signed_radix_digit_emitter_core regression: fail");
      end
      $finish;
   end

endmodule

>>> signed_radix_digit_emitter_core.f
hw/rtl/sradx_pkg.sv
hw/rtl/sradx_front.sv
hw/rtl/sradx_job_queue.sv
hw/rtl/sradx_back.sv
hw/rtl/signed_radix_digit_emitter_core.sv
bench/sradx_checker.sv
bench/tb_top.sv
